// File: src/rtc_bus_register_interface_top_macros.svh
// ----------------------------------------------------------------------------
// RTC bus register interface assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef RTC_BUS_REGISTER_INTERFACE_TOP_MACROS_SVH
`define RTC_BUS_REGISTER_INTERFACE_TOP_MACROS_SVH

`ifndef SYNTH
`define RTCBRI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcbri assertion failed");
`define RTCBRI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcbri assertion failed");
`else
`define RTCBRI_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define RTCBRI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: src/rtcbri_pkg.sv
// ----------------------------------------------------------------------------
// RTC bus register interface package
// Pin positions, time register indexes and shared types.
// ----------------------------------------------------------------------------
package rtcbri_pkg;

    localparam int PIN_OE  = 0;
    localparam int PIN_AS0 = 1;
    localparam int PIN_AS1 = 2;
    localparam int PIN_WE  = 3;
    localparam int PIN_RD  = 4;
    localparam int PIN_WR  = 5;
    localparam int PIN_ALE = 6;
    localparam int PIN_CS  = 7;

    localparam logic [7:0] IDX_SECONDS  = 8'd0;
    localparam logic [7:0] IDX_MINUTES  = 8'd2;
    localparam logic [7:0] IDX_HOURS    = 8'd4;
    localparam logic [7:0] IDX_WEEKDAY  = 8'd6;
    localparam logic [7:0] IDX_MONTHDAY = 8'd7;
    localparam logic [7:0] IDX_MONTH    = 8'd8;
    localparam logic [7:0] IDX_YEAR     = 8'd9;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_DIRECT,
        RD_REG,
        RD_SRAM
    } t_rd_sel;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [2:0] weekday;
        logic [4:0] monthday;
        logic [3:0] month;
        logic [6:0] year;
    } t_time;

    typedef struct packed {
        logic    reg_we;
        logic    reg_re;
        logic    sram_we;
        logic    sram_re;
        logic    conflict;
        t_rd_sel rd_sel;
    } t_ctl;

endpackage

// File: src/rtcbri_decode.sv
// ----------------------------------------------------------------------------
// RTC bus register interface decoder
// Edge detection, address pointers and access commands for one item.
// ----------------------------------------------------------------------------
module rtcbri_decode
    import rtcbri_pkg::*;
#(
    parameter int REGISTER_BYTES = 128,
    parameter int SRAM_BYTES     = 4096,
    parameter int REG_AW         = $clog2(REGISTER_BYTES),
    parameter int SRAM_AW        = $clog2(SRAM_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_pins,
    input  logic [7:0]         i_data,
    input  t_time              i_time,
    output t_ctl               o_ctl,
    output logic [REG_AW-1:0]  o_reg_addr,
    output logic [SRAM_AW-1:0] o_sram_addr,
    output logic [7:0]         o_direct
);

    logic [7:0]         r_prev;
    logic [REG_AW-1:0]  r_reg_ptr;
    logic [SRAM_AW-1:0] r_sram_ptr;
    logic [REG_AW-1:0]  n_reg_ptr;
    logic [SRAM_AW-1:0] n_sram_ptr;

    logic [REG_AW-1:0]  w_reg_tab [256];
    logic [SRAM_AW-1:0] w_hi_tab  [256];

    logic [7:0]         w_rising;
    logic [7:0]         w_falling;
    logic [7:0]         w_hi;
    logic [7:0]         w_lo;
    logic [15:0]        w_ptr16;
    logic [SRAM_AW:0]   w_sum;
    logic [SRAM_AW-1:0] w_reduced;

    // Byte-to-address reduction tables, worked out at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_tab
        assign w_reg_tab[g] = REG_AW'(g % REGISTER_BYTES);
        assign w_hi_tab[g]  = SRAM_AW'((g * 256) % SRAM_BYTES);
    end

    assign w_rising  = (r_prev ^ i_pins) & i_pins;
    assign w_falling = (r_prev ^ i_pins) & ~i_pins;
    assign w_ptr16   = 16'(r_sram_ptr);

    // A strobe replaces one address byte; the other byte stays.
    always_comb begin
        if (w_rising[PIN_AS0]) begin
            w_hi = w_ptr16[15:8];
            w_lo = i_data;
        end else begin
            w_hi = i_data;
            w_lo = w_ptr16[7:0];
        end
        w_sum = (SRAM_AW + 1)'(w_hi_tab[w_hi]) + (SRAM_AW + 1)'(w_lo);
        if (w_sum >= (SRAM_AW + 1)'(SRAM_BYTES)) begin
            w_reduced = SRAM_AW'(w_sum - (SRAM_AW + 1)'(SRAM_BYTES));
        end else begin
            w_reduced = SRAM_AW'(w_sum);
        end
    end

    always_comb begin
        o_ctl      = '{reg_we: 1'b0, reg_re: 1'b0, sram_we: 1'b0, sram_re: 1'b0,
                       conflict: 1'b0, rd_sel: RD_NONE};
        o_direct   = 8'd0;
        n_reg_ptr  = r_reg_ptr;
        n_sram_ptr = r_sram_ptr;
        if (!i_pins[PIN_CS]) begin
            if (i_pins[PIN_WR] && i_pins[PIN_RD] && w_falling[PIN_ALE]) begin
                n_reg_ptr = w_reg_tab[i_data];
            end else if (w_rising[PIN_WR] && i_pins[PIN_RD]) begin
                o_ctl.reg_we = 1'b1;
            end else if (i_pins[PIN_WR] && !i_pins[PIN_RD]) begin
                o_ctl.rd_sel = RD_DIRECT;
                case (8'(r_reg_ptr))
                    IDX_SECONDS:  o_direct = 8'(i_time.seconds);
                    IDX_MINUTES:  o_direct = 8'(i_time.minutes);
                    IDX_HOURS:    o_direct = 8'(i_time.hours);
                    IDX_WEEKDAY:  o_direct = 8'(i_time.weekday);
                    IDX_MONTHDAY: o_direct = 8'(i_time.monthday);
                    IDX_MONTH:    o_direct = 8'(i_time.month);
                    IDX_YEAR:     o_direct = 8'(i_time.year);
                    default: begin
                        o_ctl.rd_sel = RD_REG;
                        o_ctl.reg_re = 1'b1;
                    end
                endcase
            end
        end else begin
            if (!i_pins[PIN_WE] && !i_pins[PIN_OE]) begin
                o_ctl.conflict = 1'b1;
            end else if (w_rising[PIN_AS0] || w_rising[PIN_AS1]) begin
                n_sram_ptr = w_reduced;
            end else if (!i_pins[PIN_WE]) begin
                o_ctl.sram_we = 1'b1;
            end else if (!i_pins[PIN_OE]) begin
                o_ctl.sram_re = 1'b1;
                o_ctl.rd_sel  = RD_SRAM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 8'hFF;
            r_reg_ptr  <= '0;
            r_sram_ptr <= '0;
        end else if (i_en) begin
            r_prev     <= i_pins;
            r_reg_ptr  <= n_reg_ptr;
            r_sram_ptr <= n_sram_ptr;
        end
    end

    assign o_reg_addr  = r_reg_ptr;
    assign o_sram_addr = r_sram_ptr;

endmodule

// File: src/rtcbri_regfile.sv
// ----------------------------------------------------------------------------
// RTC bus register interface register store
// Register memory with per-entry valid bits and a registered read port.
// ----------------------------------------------------------------------------
module rtcbri_regfile
    import rtcbri_pkg::*;
#(
    parameter int REGISTER_BYTES = 128,
    parameter int REG_AW         = $clog2(REGISTER_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_ctl              i_ctl,
    input  logic [REG_AW-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0]                r_mem [REGISTER_BYTES];
    logic [REGISTER_BYTES-1:0] r_valid;
    logic [7:0]                r_rdata;
    logic                      r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.reg_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en && i_ctl.reg_re) begin
            r_rdata  <= r_mem[i_addr];
            r_rvalid <= r_valid[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en && i_ctl.reg_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // An entry not written since reset reads as zero.
    assign o_rdata = r_rvalid ? r_rdata : 8'd0;

endmodule

// File: src/rtcbri_sram.sv
// ----------------------------------------------------------------------------
// RTC bus register interface static RAM
// Byte memory with a registered read port and a clearing pass after reset.
// ----------------------------------------------------------------------------
module rtcbri_sram
    import rtcbri_pkg::*;
#(
    parameter int SRAM_BYTES = 4096,
    parameter int SRAM_AW    = $clog2(SRAM_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_ctl               i_ctl,
    input  logic [SRAM_AW-1:0] i_addr,
    input  logic [7:0]         i_wdata,
    output logic [7:0]         o_rdata,
    output logic               o_clearing
);

    logic [7:0]         r_mem [SRAM_BYTES];
    logic [7:0]         r_rdata;
    logic               r_clearing;
    logic [SRAM_AW-1:0] r_clr_addr;
    logic               w_we;
    logic [SRAM_AW-1:0] w_waddr;
    logic [7:0]         w_wdata;

    assign w_we    = r_clearing || (i_en && i_ctl.sram_we);
    assign w_waddr = r_clearing ? r_clr_addr : i_addr;
    assign w_wdata = r_clearing ? 8'd0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_en && i_ctl.sram_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + SRAM_AW'(1);
            if (r_clr_addr == SRAM_AW'(SRAM_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

// File: src/rtc_bus_register_interface_top.sv
// ----------------------------------------------------------------------------
// RTC bus register interface
// Bus front end of a real-time clock with a register store and static RAM.
// ----------------------------------------------------------------------------
// Items enter on the slave stream: one item per bus sample, carrying the pin
// lines, the data byte and the current calendar time. Every item gives one
// result on the master stream: the output data latch in tdata and the
// WE/OE conflict flag in tuser.
// The path is three registers deep: input register, decode and memory read,
// result register. One item per cycle is sustained while the receiver does
// not stall, bounded by the single access port of each memory.
// After reset the static RAM is cleared one byte per cycle, all SRAM_BYTES
// bytes in turn, and s_axis_tready stays low until that pass is done.
// When the receiver stalls, each stage fills in turn; up to three items are
// held before s_axis_tready falls.
// ----------------------------------------------------------------------------
`include "rtc_bus_register_interface_top_macros.svh"

module rtc_bus_register_interface_top
    import rtcbri_pkg::*;
#(
    parameter int REGISTER_BYTES = 128,
    parameter int SRAM_BYTES     = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // pin_lines[7:0], bus_byte[15:8], now_seconds[21:16], now_minutes[27:22],
    // now_hours[32:28], now_weekday[35:33], now_monthday[40:36],
    // now_month[44:41], now_year[51:45], zero fill[55:52]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    // conflict_flag[0]
    output logic [0:0]  o_m_axis_tuser
);

    localparam int REG_AW  = $clog2(REGISTER_BYTES);
    localparam int SRAM_AW = $clog2(SRAM_BYTES);

    logic               r_s1_valid;
    logic [7:0]         r_s1_pins;
    logic [7:0]         r_s1_data;
    t_time              r_s1_time;
    logic               r_s2_valid;
    t_rd_sel            r_s2_sel;
    logic [7:0]         r_s2_direct;
    logic               r_s2_conflict;
    logic               r_out_valid;
    logic [7:0]         r_out_data;
    logic               r_out_conflict;
    logic [7:0]         n_out_data;

    logic               w_s1_ready;
    logic               w_s2_ready;
    logic               w_s3_ready;
    logic               w_s1_go;
    logic               w_s2_go;
    logic               w_accept;
    logic               w_clearing;
    t_ctl               w_ctl;
    logic [REG_AW-1:0]  w_reg_addr;
    logic [SRAM_AW-1:0] w_sram_addr;
    logic [7:0]         w_direct;
    logic [7:0]         w_reg_rdata;
    logic [7:0]         w_sram_rdata;

    assign w_s3_ready      = !r_out_valid || i_m_axis_tready;
    assign w_s2_ready      = !r_s2_valid || w_s3_ready;
    assign w_s1_ready      = !r_s1_valid || w_s2_ready;
    assign w_s1_go         = r_s1_valid && w_s2_ready;
    assign w_s2_go         = r_s2_valid && w_s3_ready;
    assign o_s_axis_tready = w_s1_ready && !w_clearing;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pins <= i_s_axis_tdata[7:0];
            r_s1_data <= i_s_axis_tdata[15:8];
            r_s1_time <= '{seconds:  i_s_axis_tdata[21:16],
                           minutes:  i_s_axis_tdata[27:22],
                           hours:    i_s_axis_tdata[32:28],
                           weekday:  i_s_axis_tdata[35:33],
                           monthday: i_s_axis_tdata[40:36],
                           month:    i_s_axis_tdata[44:41],
                           year:     i_s_axis_tdata[51:45]};
        end
    end

    rtcbri_decode #(
        .REGISTER_BYTES (REGISTER_BYTES),
        .SRAM_BYTES     (SRAM_BYTES),
        .REG_AW         (REG_AW),
        .SRAM_AW        (SRAM_AW)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_s1_go),
        .i_pins      (r_s1_pins),
        .i_data      (r_s1_data),
        .i_time      (r_s1_time),
        .o_ctl       (w_ctl),
        .o_reg_addr  (w_reg_addr),
        .o_sram_addr (w_sram_addr),
        .o_direct    (w_direct)
    );

    rtcbri_regfile #(
        .REGISTER_BYTES (REGISTER_BYTES),
        .REG_AW         (REG_AW)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_s1_go),
        .i_ctl   (w_ctl),
        .i_addr  (w_reg_addr),
        .i_wdata (r_s1_data),
        .o_rdata (w_reg_rdata)
    );

    rtcbri_sram #(
        .SRAM_BYTES (SRAM_BYTES),
        .SRAM_AW    (SRAM_AW)
    ) u_sram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_s1_go),
        .i_ctl      (w_ctl),
        .i_addr     (w_sram_addr),
        .i_wdata    (r_s1_data),
        .o_rdata    (w_sram_rdata),
        .o_clearing (w_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_go) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_s2_sel      <= w_ctl.rd_sel;
            r_s2_direct   <= w_direct;
            r_s2_conflict <= w_ctl.conflict;
        end
    end

    always_comb begin
        case (r_s2_sel)
            RD_DIRECT: n_out_data = r_s2_direct;
            RD_REG:    n_out_data = w_reg_rdata;
            RD_SRAM:   n_out_data = w_sram_rdata;
            default:   n_out_data = r_out_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_out_data     <= 8'd0;
            r_out_conflict <= 1'b0;
        end else begin
            if (w_s2_go) begin
                r_out_valid    <= 1'b1;
                r_out_data     <= n_out_data;
                r_out_conflict <= r_s2_conflict;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_conflict;

    `RTCBRI_ASSERT_IMPL(a_conflict_no_access, i_clk, i_rst_n, w_s1_go && w_ctl.conflict, !(w_ctl.reg_we || w_ctl.reg_re || w_ctl.sram_we || w_ctl.sram_re))
    `RTCBRI_ASSERT_NEXT(a_conflict_keeps_latch, i_clk, i_rst_n, w_s2_go && r_s2_conflict, r_out_data == $past(r_out_data))
    `RTCBRI_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, !w_clearing, !w_clearing)
    `RTCBRI_ASSERT_NEXT(a_s2_holds, i_clk, i_rst_n, r_s2_valid && !w_s3_ready, r_s2_valid && $stable(r_s2_sel))

endmodule
